FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// check at every clock edge outside reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/u16_pkg.sv
// ----------------------------------------------------------------------------
// u16_pkg
// Shared constants, codes and types of the 16550-style register block.
// ----------------------------------------------------------------------------
package u16_pkg;

  // FIFO geometry
  localparam int RX_DEPTH = 16;
  localparam int TX_DEPTH = 16;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_FW    = $clog2(RX_DEPTH + 1);
  localparam int TX_FW    = $clog2(TX_DEPTH + 1);

  // transaction kinds
  typedef enum logic [1:0] {
    OP_BUS_READ    = 2'd0,
    OP_BUS_WRITE   = 2'd1,
    OP_HOST_RX     = 2'd2,
    OP_HOST_DRAIN  = 2'd3
  } op_t;

  // register offsets
  localparam logic [2:0] REG_RBR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  localparam logic [3:0] VALID_SIZE  = 4'd1;

  // fixed values and bit positions
  localparam logic [7:0]  IIR_VALUE     = 8'hC0;
  localparam logic [7:0]  LSR_RESET     = 8'h60;
  localparam logic [15:0] DIV_RESET     = 16'h0001;
  localparam int          LSR_DR_BIT    = 0;
  localparam int          LSR_THRE_BIT  = 5;
  localparam int          LSR_TEMT_BIT  = 6;
  localparam int          FCR_RXCLR_BIT = 1;
  localparam int          FCR_TXCLR_BIT = 2;
  localparam int          LCR_DLAB_BIT  = 7;

  // one input transaction
  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] reg_offset;
    logic [3:0] access_size;
    logic [7:0] data_byte;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       error;
    logic       rx_accepted;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       console_valid;
    logic [7:0] console_byte;
    logic [7:0] line_status;
  } result_t;

  // result waiting for FIFO read data
  typedef struct packed {
    logic    from_rx;
    result_t res;
  } pend_t;

  // FIFO store access commands
  typedef struct packed {
    logic             wr_en;
    logic [RX_AW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [RX_AW-1:0] rd_addr;
  } rx_cmd_t;

  typedef struct packed {
    logic             wr_en;
    logic [TX_AW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [TX_AW-1:0] rd_addr;
  } tx_cmd_t;

endpackage

FILE: rtl/core/u16_chan_if.sv
// ----------------------------------------------------------------------------
// u16 channel interfaces
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface u16_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] reg_offset;
  logic [3:0] access_size;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output reg_offset,
                  output access_size, output data_byte, input ready);
  modport sink   (input valid, input operation, input reg_offset,
                  input access_size, input data_byte, output ready);
endinterface

interface u16_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       error;
  logic       rx_accepted;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       console_valid;
  logic [7:0] console_byte;
  logic [7:0] line_status;

  modport source (output valid, output read_data, output error, output rx_accepted,
                  output tx_valid, output tx_byte, output console_valid,
                  output console_byte, output line_status, input ready);
  modport sink   (input valid, input read_data, input error, input rx_accepted,
                  input tx_valid, input tx_byte, input console_valid,
                  input console_byte, input line_status, output ready);
endinterface

FILE: rtl/core/u16_ram.sv
// ----------------------------------------------------------------------------
// u16_ram
// Byte-wide simple dual-port RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module u16_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/u16_ctrl.sv
// ----------------------------------------------------------------------------
// u16_ctrl
// Register file, FIFO pointers and line status; decodes each transaction.
// ----------------------------------------------------------------------------
module u16_ctrl
  import u16_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output rx_cmd_t rx_cmd,
  output tx_cmd_t tx_cmd,
  output pend_t   pend
);

  logic [RX_AW-1:0] rx_wr_ptr_r, rx_wr_ptr_nxt, rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic [RX_FW-1:0] rx_fill_r, rx_fill_nxt;
  logic [TX_AW-1:0] tx_wr_ptr_r, tx_wr_ptr_nxt, tx_rd_ptr_r, tx_rd_ptr_nxt;
  logic [TX_FW-1:0] tx_fill_r, tx_fill_nxt;
  logic [3:0]       ier_r, ier_nxt;
  logic [7:0]       lcr_r, lcr_nxt;
  logic [4:0]       mcr_r, mcr_nxt;
  logic [7:0]       scr_r, scr_nxt;
  logic [7:0]       lsr_r, lsr_nxt;
  logic [15:0]      div_r, div_nxt;

  op_t              op;
  logic [2:0]       reg_sel;
  logic             bus_ok;
  logic             dlab;
  logic             rx_full, rx_empty, tx_full, tx_empty;
  logic [RX_AW-1:0] rx_wr_inc, rx_rd_inc;
  logic [TX_AW-1:0] tx_wr_inc, tx_rd_inc;

  assign op       = op_t'(item.operation);
  assign reg_sel  = item.reg_offset[2:0];
  assign bus_ok   = !item.reg_offset[3] && (item.access_size == VALID_SIZE);
  assign dlab     = lcr_r[LCR_DLAB_BIT];
  assign rx_full  = (rx_fill_r == RX_FW'(RX_DEPTH));
  assign rx_empty = (rx_fill_r == '0);
  assign tx_full  = (tx_fill_r == TX_FW'(TX_DEPTH));
  assign tx_empty = (tx_fill_r == '0);

  // wrap pointers at the FIFO depth
  assign rx_wr_inc = (rx_wr_ptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr_r + 1'b1;
  assign rx_rd_inc = (rx_rd_ptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr_r + 1'b1;
  assign tx_wr_inc = (tx_wr_ptr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr_r + 1'b1;
  assign tx_rd_inc = (tx_rd_ptr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr_r + 1'b1;

  // decode the transaction, update state and issue store accesses
  always_comb begin
    rx_wr_ptr_nxt = rx_wr_ptr_r;
    rx_rd_ptr_nxt = rx_rd_ptr_r;
    rx_fill_nxt   = rx_fill_r;
    tx_wr_ptr_nxt = tx_wr_ptr_r;
    tx_rd_ptr_nxt = tx_rd_ptr_r;
    tx_fill_nxt   = tx_fill_r;
    ier_nxt       = ier_r;
    lcr_nxt       = lcr_r;
    mcr_nxt       = mcr_r;
    scr_nxt       = scr_r;
    lsr_nxt       = lsr_r;
    div_nxt       = div_r;
    rx_cmd        = '0;
    tx_cmd        = '0;
    pend          = '0;
    rx_cmd.wr_addr = rx_wr_ptr_r;
    rx_cmd.wr_data = item.data_byte;
    rx_cmd.rd_addr = rx_rd_ptr_r;
    tx_cmd.wr_addr = tx_wr_ptr_r;
    tx_cmd.wr_data = item.data_byte;
    tx_cmd.rd_addr = tx_rd_ptr_r;

    if (fire) begin
      unique case (op)
        OP_BUS_READ: begin
          if (!bus_ok) begin
            pend.res.error = 1'b1;
          end else if (dlab && reg_sel == REG_RBR_THR) begin
            pend.res.read_data = div_r[7:0];
          end else if (dlab && reg_sel == REG_IER) begin
            pend.res.read_data = div_r[15:8];
          end else begin
            unique case (reg_sel)
              REG_RBR_THR: begin
                // pop the receive FIFO, data arrives from the store next cycle
                if (!rx_empty) begin
                  rx_cmd.rd_en  = 1'b1;
                  pend.from_rx  = 1'b1;
                  rx_rd_ptr_nxt = rx_rd_inc;
                  rx_fill_nxt   = rx_fill_r - 1'b1;
                  if (rx_fill_r == RX_FW'(1)) begin
                    lsr_nxt[LSR_DR_BIT] = 1'b0;
                  end
                end
              end
              REG_IER:     pend.res.read_data = {4'h0, ier_r};
              REG_IIR_FCR: pend.res.read_data = IIR_VALUE;
              REG_LCR:     pend.res.read_data = lcr_r;
              REG_MCR:     pend.res.read_data = {3'h0, mcr_r};
              REG_LSR:     pend.res.read_data = lsr_r;
              REG_MSR:     pend.res.read_data = 8'h00;
              REG_SCR:     pend.res.read_data = scr_r;
              default:     pend.res.read_data = 8'h00;
            endcase
          end
        end
        OP_BUS_WRITE: begin
          if (!bus_ok) begin
            pend.res.error = 1'b1;
          end else if (dlab && reg_sel == REG_RBR_THR) begin
            div_nxt[7:0] = item.data_byte;
          end else if (dlab && reg_sel == REG_IER) begin
            div_nxt[15:8] = item.data_byte;
          end else begin
            unique case (reg_sel)
              REG_RBR_THR: begin
                // push into the transmit FIFO and echo to the console
                if (!tx_full) begin
                  tx_cmd.wr_en            = 1'b1;
                  tx_wr_ptr_nxt           = tx_wr_inc;
                  tx_fill_nxt             = tx_fill_r + 1'b1;
                  lsr_nxt[LSR_THRE_BIT]   = 1'b0;
                  lsr_nxt[LSR_TEMT_BIT]   = 1'b0;
                  pend.res.console_valid  = 1'b1;
                  pend.res.console_byte   = item.data_byte;
                end
              end
              REG_IER: ier_nxt = item.data_byte[3:0];
              REG_IIR_FCR: begin
                if (item.data_byte[FCR_RXCLR_BIT]) begin
                  rx_wr_ptr_nxt       = '0;
                  rx_rd_ptr_nxt       = '0;
                  rx_fill_nxt         = '0;
                  lsr_nxt[LSR_DR_BIT] = 1'b0;
                end
                if (item.data_byte[FCR_TXCLR_BIT]) begin
                  tx_wr_ptr_nxt         = '0;
                  tx_rd_ptr_nxt         = '0;
                  tx_fill_nxt           = '0;
                  lsr_nxt[LSR_THRE_BIT] = 1'b1;
                  lsr_nxt[LSR_TEMT_BIT] = 1'b1;
                end
              end
              REG_LCR: lcr_nxt = item.data_byte;
              REG_MCR: mcr_nxt = item.data_byte[4:0];
              REG_SCR: scr_nxt = item.data_byte;
              default: ;
            endcase
          end
        end
        OP_HOST_RX: begin
          // drop the byte when the receive FIFO is full
          if (!rx_full) begin
            rx_cmd.wr_en         = 1'b1;
            rx_wr_ptr_nxt        = rx_wr_inc;
            rx_fill_nxt          = rx_fill_r + 1'b1;
            pend.res.rx_accepted = 1'b1;
          end
          lsr_nxt[LSR_DR_BIT] = 1'b1;
        end
        OP_HOST_DRAIN: begin
          if (!tx_empty) begin
            tx_cmd.rd_en      = 1'b1;
            pend.res.tx_valid = 1'b1;
            tx_rd_ptr_nxt     = tx_rd_inc;
            tx_fill_nxt       = tx_fill_r - 1'b1;
          end
          if (tx_fill_r <= TX_FW'(1)) begin
            lsr_nxt[LSR_THRE_BIT] = 1'b1;
            lsr_nxt[LSR_TEMT_BIT] = 1'b1;
          end
        end
        default: ;
      endcase
    end
    pend.res.line_status = lsr_nxt;
  end

  // hold register and pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_ptr_r <= '0;
      rx_rd_ptr_r <= '0;
      rx_fill_r   <= '0;
      tx_wr_ptr_r <= '0;
      tx_rd_ptr_r <= '0;
      tx_fill_r   <= '0;
      ier_r       <= '0;
      lcr_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      lsr_r       <= LSR_RESET;
      div_r       <= DIV_RESET;
    end else begin
      rx_wr_ptr_r <= rx_wr_ptr_nxt;
      rx_rd_ptr_r <= rx_rd_ptr_nxt;
      rx_fill_r   <= rx_fill_nxt;
      tx_wr_ptr_r <= tx_wr_ptr_nxt;
      tx_rd_ptr_r <= tx_rd_ptr_nxt;
      tx_fill_r   <= tx_fill_nxt;
      ier_r       <= ier_nxt;
      lcr_r       <= lcr_nxt;
      mcr_r       <= mcr_nxt;
      scr_r       <= scr_nxt;
      lsr_r       <= lsr_nxt;
      div_r       <= div_nxt;
    end
  end

endmodule

FILE: rtl/core/uart_16550_register_model_top.sv
// ----------------------------------------------------------------------------
// uart_16550_register_model_top
// 16550-style UART register block with receive and transmit FIFOs.
// ----------------------------------------------------------------------------
// in_chan carries one transaction per handshake: a bus read, a bus write, a
// host byte for the receive FIFO or a drain of one transmit byte. out_chan
// returns exactly one result transaction for each input transaction, in order.
// Registers, pointers and line status update at the accepting edge; FIFO
// bytes live in two RAMs with a registered read. A result passes through
// the pending stage, while the store read completes, and then the output
// register before it is offered on out_chan.
// Throughput is one transaction per cycle while out_chan is ready; the
// pending stage hands over to the output register at the same edge at which
// the next transaction is accepted.
// If out_chan stalls, the output register and the pending stage both fill
// and in_chan.ready drops until the output register is taken.
// Reset (rst_n low, synchronous) empties both FIFOs, clears IER, LCR, MCR
// and SCR, sets LSR to THRE|TEMT and the divisor to one, and drops both
// valids. FIFO contents are not cleared; they are only read when filled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_16550_register_model_top
  import u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  u16_in_if.sink      in_chan,
  u16_out_if.source   out_chan
);

  item_t   item;
  rx_cmd_t rx_cmd;
  tx_cmd_t tx_cmd;
  pend_t   pend;
  pend_t   pend_r;
  result_t out_r, out_nxt;
  logic    pend_valid_r, out_valid_r;
  logic    pend_move, fire;
  logic [7:0] rx_rd_data, tx_rd_data;

  // handshake
  assign pend_move     = pend_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !pend_valid_r || pend_move;
  assign fire          = in_chan.valid && in_chan.ready;

  assign item.operation   = in_chan.operation;
  assign item.reg_offset  = in_chan.reg_offset;
  assign item.access_size = in_chan.access_size;
  assign item.data_byte   = in_chan.data_byte;

  u16_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .rx_cmd (rx_cmd),
    .tx_cmd (tx_cmd),
    .pend   (pend)
  );

  u16_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_cmd.wr_en),
    .wr_addr (rx_cmd.wr_addr),
    .wr_data (rx_cmd.wr_data),
    .rd_en   (rx_cmd.rd_en),
    .rd_addr (rx_cmd.rd_addr),
    .rd_data (rx_rd_data)
  );

  u16_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_cmd.wr_en),
    .wr_addr (tx_cmd.wr_addr),
    .wr_data (tx_cmd.wr_data),
    .rd_en   (tx_cmd.rd_en),
    .rd_addr (tx_cmd.rd_addr),
    .rd_data (tx_rd_data)
  );

  // merge FIFO read data into the pending result
  always_comb begin
    out_nxt = pend_r.res;
    if (pend_r.from_rx) begin
      out_nxt.read_data = rx_rd_data;
    end
    out_nxt.tx_byte = pend_r.res.tx_valid ? tx_rd_data : 8'h00;
  end

  // advance valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        pend_valid_r <= 1'b1;
      end else if (pend_move) begin
        pend_valid_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold payloads
  always_ff @(posedge clk) begin
    if (fire) begin
      pend_r <= pend;
    end
    if (pend_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.read_data     = out_r.read_data;
  assign out_chan.error         = out_r.error;
  assign out_chan.rx_accepted   = out_r.rx_accepted;
  assign out_chan.tx_valid      = out_r.tx_valid;
  assign out_chan.tx_byte       = out_r.tx_byte;
  assign out_chan.console_valid = out_r.console_valid;
  assign out_chan.console_byte  = out_r.console_byte;
  assign out_chan.line_status   = out_r.line_status;

  // a rejected bus access has no side effects and returns zero
  `ASSERT_RST(a_error_clean,
    out_valid_r && out_r.error |-> out_r.read_data == 8'h00 && !out_r.console_valid
      && !out_r.tx_valid && !out_r.rx_accepted,
    "error result carries data or side effects")
  // an accepted transmit write leaves THRE and TEMT clear
  `ASSERT_RST(a_console_lsr,
    out_valid_r && out_r.console_valid |-> !out_r.line_status[LSR_THRE_BIT]
      && !out_r.line_status[LSR_TEMT_BIT],
    "console echo with THRE or TEMT set")
  // a host byte always leaves data ready set
  `ASSERT_RST(a_rx_dr, out_valid_r && out_r.rx_accepted |-> out_r.line_status[LSR_DR_BIT],
    "receive push without DR")
  // no result is offered in the cycle after reset
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && !pend_valid_r, "valid after reset")

endmodule
